@@ src/gprd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package gprd_pkg;

  localparam int SQRT_STAGES = 16;
  localparam int DIV_STAGES  = 16;
  localparam int DIV_W       = 32;
  localparam int Q_BITS      = 15;
  localparam int STICK_FRONT = 4 + SQRT_STAGES;
  localparam int TRIG_PAD    = STICK_FRONT - 1;
  localparam int LANE_LAT    = STICK_FRONT + DIV_STAGES + 1;
  localparam int TOTAL_LAT   = LANE_LAT + 2;

  localparam int ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_LEFT_DEAD_ZONE   = 3'd0,
    REG_LEFT_RADIUS      = 3'd1,
    REG_RIGHT_DEAD_ZONE  = 3'd2,
    REG_RIGHT_RADIUS     = 3'd3,
    REG_LEFT_THRESHOLD   = 3'd4,
    REG_RIGHT_THRESHOLD  = 3'd5
  } cfg_idx_t;

  localparam logic [14:0] RST_LEFT_DEAD_ZONE  = 15'd7849;
  localparam logic [15:0] RST_LEFT_RADIUS     = 16'd32767;
  localparam logic [14:0] RST_RIGHT_DEAD_ZONE = 15'd8689;
  localparam logic [15:0] RST_RIGHT_RADIUS    = 16'd32767;
  localparam logic [7:0]  RST_THRESHOLD       = 8'd30;
  localparam logic [7:0]  TRIGGER_FULL        = 8'd255;
  localparam logic [Q_BITS-1:0] Q15_MAX       = 15'h7fff;

endpackage
`default_nettype wire

@@ src/gprd_isqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gprd_isqrt (
  input  logic        clk,
  input  logic [31:0] s,
  output logic [15:0] root
);

  logic [31:0] rem  [0:gprd_pkg::SQRT_STAGES];
  logic [15:0] rt   [0:gprd_pkg::SQRT_STAGES];

  assign rem[0] = s;
  assign rt[0]  = 16'd0;

  for (genvar k = 0; k < gprd_pkg::SQRT_STAGES; k++) begin : g_step
    localparam int B = gprd_pkg::SQRT_STAGES - 1 - k;
    logic [33:0] cand;
    logic        ge;
    always_comb begin
      cand = ({18'd0, rt[k]} << (B + 1)) + (34'd1 << (2 * B));
      ge   = {2'b00, rem[k]} >= cand;
    end
    always_ff @(posedge clk) begin
      rem[k+1] <= ge ? (rem[k] - cand[31:0]) : rem[k];
      rt[k+1]  <= ge ? (rt[k] | (16'd1 << B)) : rt[k];
    end
  end

  assign root = rt[gprd_pkg::SQRT_STAGES];

endmodule
`default_nettype wire

@@ src/gprd_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gprd_div (
  input  logic                        clk,
  input  logic [gprd_pkg::DIV_W-1:0]  num,
  input  logic [gprd_pkg::DIV_W-1:0]  den,
  output logic [gprd_pkg::Q_BITS-1:0] quo,
  output logic                        sat
);

  localparam int N = gprd_pkg::DIV_STAGES;
  localparam int W = gprd_pkg::DIV_W;
  localparam int Q = gprd_pkg::Q_BITS;

  logic [W-1:0] rem [0:N-1];
  logic [W-1:0] dv  [0:N-1];
  logic [Q-1:0] q   [0:N-1];
  logic         sf  [0:N-1];

  always_ff @(posedge clk) begin
    rem[0] <= num;
    dv[0]  <= den;
    sf[0]  <= num >= den;
    q[0]   <= '0;
  end

  for (genvar k = 1; k < N; k++) begin : g_step
    logic [W:0] r2;
    logic [W:0] diff;
    logic       ge;
    always_comb begin
      r2   = {rem[k-1], 1'b0};
      ge   = r2 >= {1'b0, dv[k-1]};
      diff = r2 - {1'b0, dv[k-1]};
    end
    always_ff @(posedge clk) begin
      rem[k] <= ge ? diff[W-1:0] : r2[W-1:0];
      dv[k]  <= dv[k-1];
      sf[k]  <= sf[k-1];
      q[k]   <= {q[k-1][Q-2:0], ge};
    end
  end

  assign quo = q[N-1];
  assign sat = sf[N-1];

endmodule
`default_nettype wire

@@ src/gprd_stick_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gprd_stick_lane (
  input  logic               clk,
  input  logic signed [15:0] x,
  input  logic signed [15:0] y,
  input  logic [14:0]        dead_zone,
  input  logic [15:0]        radius,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y
);

  localparam int S = gprd_pkg::SQRT_STAGES;
  localparam int D = gprd_pkg::DIV_STAGES;

  logic signed [31:0] xx_full, yy_full;
  logic [30:0] xx, yy;
  logic [29:0] dd;
  logic [15:0] ax1, ay1;
  logic        nx1, ny1;

  assign xx_full = x * x;
  assign yy_full = y * y;

  always_ff @(posedge clk) begin
    xx  <= xx_full[30:0];
    yy  <= yy_full[30:0];
    dd  <= dead_zone * dead_zone;
    ax1 <= x[15] ? 16'(~x + 16'sd1) : 16'(x);
    ay1 <= y[15] ? 16'(~y + 16'sd1) : 16'(y);
    nx1 <= x[15];
    ny1 <= y[15];
  end

  logic [31:0] s_comb, s;
  logic [15:0] axd [0:S];
  logic [15:0] ayd [0:S];
  logic        nxd [0:S];
  logic        nyd [0:S];
  logic        lvd [0:S];

  assign s_comb = {1'b0, xx} + {1'b0, yy};

  always_ff @(posedge clk) begin
    s      <= s_comb;
    lvd[0] <= s_comb > {2'b00, dd};
    axd[0] <= ax1;
    ayd[0] <= ay1;
    nxd[0] <= nx1;
    nyd[0] <= ny1;
  end

  for (genvar k = 0; k < S; k++) begin : g_side
    always_ff @(posedge clk) begin
      axd[k+1] <= axd[k];
      ayd[k+1] <= ayd[k];
      nxd[k+1] <= nxd[k];
      nyd[k+1] <= nyd[k];
      lvd[k+1] <= lvd[k];
    end
  end

  logic [15:0] m;

  gprd_isqrt u_isqrt (
    .clk  (clk),
    .s    (s),
    .root (m)
  );

  logic [15:0] cl, dz16;
  logic        deg;
  logic [15:0] nnum, rd, m_p, ax_p, ay_p;
  logic        zf  [0:D+1];
  logic        sxf [0:D+1];
  logic        syf [0:D+1];

  always_comb begin
    dz16 = {1'b0, dead_zone};
    cl   = (m < radius) ? m : radius;
    deg  = radius <= dz16;
  end

  always_ff @(posedge clk) begin
    nnum   <= deg ? 16'd1 : 16'(cl - dz16);
    rd     <= deg ? 16'd1 : 16'(radius - dz16);
    m_p    <= m;
    ax_p   <= axd[S];
    ay_p   <= ayd[S];
    zf[0]  <= !lvd[S] || (!deg && (cl <= dz16));
    sxf[0] <= nxd[S];
    syf[0] <= nyd[S];
  end

  logic [31:0] den_m, num_x, num_y;

  always_ff @(posedge clk) begin
    den_m <= m_p * rd;
    num_x <= ax_p * nnum;
    num_y <= ay_p * nnum;
  end

  for (genvar k = 0; k <= D; k++) begin : g_flag
    always_ff @(posedge clk) begin
      zf[k+1]  <= zf[k];
      sxf[k+1] <= sxf[k];
      syf[k+1] <= syf[k];
    end
  end

  logic [gprd_pkg::Q_BITS-1:0] qx, qy;
  logic                        satx, saty;

  gprd_div u_div_x (.clk(clk), .num(num_x), .den(den_m), .quo(qx), .sat(satx));
  gprd_div u_div_y (.clk(clk), .num(num_y), .den(den_m), .quo(qy), .sat(saty));

  logic [15:0] mx, my;

  always_comb begin
    mx = {1'b0, satx ? gprd_pkg::Q15_MAX : qx};
    my = {1'b0, saty ? gprd_pkg::Q15_MAX : qy};
  end

  always_ff @(posedge clk) begin
    out_x <= zf[D+1] ? 16'sd0 : (sxf[D+1] ? signed'(16'(~mx + 16'd1)) : signed'(mx));
    out_y <= zf[D+1] ? 16'sd0 : (syf[D+1] ? signed'(16'(~my + 16'd1)) : signed'(my));
  end

endmodule
`default_nettype wire

@@ src/gprd_trigger_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gprd_trigger_lane (
  input  logic        clk,
  input  logic [7:0]  pull,
  input  logic [7:0]  threshold,
  output logic [14:0] pull_out
);

  localparam int P = gprd_pkg::TRIG_PAD;
  localparam int D = gprd_pkg::DIV_STAGES;

  logic [7:0] an [0:P];
  logic [7:0] dn [0:P];
  logic       zf [0:P+D];

  always_ff @(posedge clk) begin
    an[0] <= (pull > threshold) ? 8'(pull - threshold) : 8'd0;
    dn[0] <= 8'(gprd_pkg::TRIGGER_FULL - threshold);
    zf[0] <= pull <= threshold;
  end

  for (genvar k = 0; k < P; k++) begin : g_pad
    always_ff @(posedge clk) begin
      an[k+1] <= an[k];
      dn[k+1] <= dn[k];
    end
  end

  for (genvar k = 0; k < P + D; k++) begin : g_flag
    always_ff @(posedge clk) begin
      zf[k+1] <= zf[k];
    end
  end

  logic [gprd_pkg::Q_BITS-1:0] q;
  logic                        sat;

  gprd_div u_div (
    .clk (clk),
    .num ({24'd0, an[P]}),
    .den ({24'd0, dn[P]}),
    .quo (q),
    .sat (sat)
  );

  always_ff @(posedge clk) begin
    pull_out <= zf[P+D] ? 15'd0 : (sat ? gprd_pkg::Q15_MAX : q);
  end

endmodule
`default_nettype wire

@@ src/gamepad_radial_deadzone_conditioner.sv @@
`timescale 1ns / 1ps
`default_nettype none
// channel   | handshake              | payload
// ----------+------------------------+------------------------------------------
// input     | start, busy            | left_x, left_y, right_x, right_y, *_pull
// result    | done (one-cycle pulse) | left/right_out_x/y, *_pull_out
// config    | APB psel/penable/...   | paddr, pwdata, prdata
// One item per cycle; busy stays low. Each item's result passes through the
// 16-stage square root and the 16-stage divider before done rises.
// Synchronous reset clears the pipeline valid bits and done, and loads the config registers with their defaults.
// Results cannot be held off; items in flight keep moving every cycle.
module gamepad_radial_deadzone_conditioner (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [15:0]          left_x,
  input  logic signed [15:0]          left_y,
  input  logic signed [15:0]          right_x,
  input  logic signed [15:0]          right_y,
  input  logic [7:0]                  left_pull,
  input  logic [7:0]                  right_pull,
  output logic                        done,
  output logic signed [15:0]          left_out_x,
  output logic signed [15:0]          left_out_y,
  output logic signed [15:0]          right_out_x,
  output logic signed [15:0]          right_out_y,
  output logic [14:0]                 left_pull_out,
  output logic [14:0]                 right_pull_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gprd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int L = gprd_pkg::LANE_LAT;

  logic [14:0] left_dead_zone, right_dead_zone;
  logic [15:0] left_radius, right_radius;
  logic [7:0]  left_trigger_threshold, right_trigger_threshold;
  logic [2:0]  idx;
  logic        wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_dead_zone          <= gprd_pkg::RST_LEFT_DEAD_ZONE;
      left_radius             <= gprd_pkg::RST_LEFT_RADIUS;
      right_dead_zone         <= gprd_pkg::RST_RIGHT_DEAD_ZONE;
      right_radius            <= gprd_pkg::RST_RIGHT_RADIUS;
      left_trigger_threshold  <= gprd_pkg::RST_THRESHOLD;
      right_trigger_threshold <= gprd_pkg::RST_THRESHOLD;
    end else if (wr) begin
      unique case (idx)
        gprd_pkg::REG_LEFT_DEAD_ZONE:  left_dead_zone          <= pwdata[14:0];
        gprd_pkg::REG_LEFT_RADIUS:     left_radius             <= pwdata[15:0];
        gprd_pkg::REG_RIGHT_DEAD_ZONE: right_dead_zone         <= pwdata[14:0];
        gprd_pkg::REG_RIGHT_RADIUS:    right_radius            <= pwdata[15:0];
        gprd_pkg::REG_LEFT_THRESHOLD:  left_trigger_threshold  <= pwdata[7:0];
        gprd_pkg::REG_RIGHT_THRESHOLD: right_trigger_threshold <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      gprd_pkg::REG_LEFT_DEAD_ZONE:  prdata = {17'd0, left_dead_zone};
      gprd_pkg::REG_LEFT_RADIUS:     prdata = {16'd0, left_radius};
      gprd_pkg::REG_RIGHT_DEAD_ZONE: prdata = {17'd0, right_dead_zone};
      gprd_pkg::REG_RIGHT_RADIUS:    prdata = {16'd0, right_radius};
      gprd_pkg::REG_LEFT_THRESHOLD:  prdata = {24'd0, left_trigger_threshold};
      gprd_pkg::REG_RIGHT_THRESHOLD: prdata = {24'd0, right_trigger_threshold};
      default:                       prdata = 32'd0;
    endcase
  end

  logic signed [15:0] lx, ly, rx, ry;
  logic [7:0]         lp, rp;
  logic               vld [0:L];

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      lx <= left_x;
      ly <= left_y;
      rx <= right_x;
      ry <= right_y;
      lp <= left_pull;
      rp <= right_pull;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= start && !busy;
    end
  end

  for (genvar k = 0; k < L; k++) begin : g_vld
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end
  end

  logic signed [15:0] l_ox, l_oy, r_ox, r_oy;
  logic [14:0]        l_po, r_po;

  gprd_stick_lane u_left (
    .clk (clk), .x (lx), .y (ly), .dead_zone (left_dead_zone),
    .radius (left_radius), .out_x (l_ox), .out_y (l_oy)
  );

  gprd_stick_lane u_right (
    .clk (clk), .x (rx), .y (ry), .dead_zone (right_dead_zone),
    .radius (right_radius), .out_x (r_ox), .out_y (r_oy)
  );

  gprd_trigger_lane u_ltrig (
    .clk (clk), .pull (lp), .threshold (left_trigger_threshold), .pull_out (l_po)
  );

  gprd_trigger_lane u_rtrig (
    .clk (clk), .pull (rp), .threshold (right_trigger_threshold), .pull_out (r_po)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[L];
    end
  end

  always_ff @(posedge clk) begin
    if (vld[L]) begin
      left_out_x     <= l_ox;
      left_out_y     <= l_oy;
      right_out_x    <= r_ox;
      right_out_y    <= r_oy;
      left_pull_out  <= l_po;
      right_pull_out <= r_po;
    end
  end

endmodule
`default_nettype wire

@@ src/gprd_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gprd_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [15:0] left_out_x,
  input logic signed [15:0] left_out_y,
  input logic signed [15:0] right_out_x,
  input logic signed [15:0] right_out_y,
  input logic               pready
);

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(gprd_pkg::TOTAL_LAT) done)
    else $error("item result missing at expected latency");

  a_no_phantom: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (left_out_x != 16'sh8000 && left_out_y != 16'sh8000 &&
              right_out_x != 16'sh8000 && right_out_y != 16'sh8000))
    else $error("stick output outside Q1.15 range");

  a_ready: assert property (@(posedge clk) pready)
    else $error("pready dropped");

endmodule

bind gamepad_radial_deadzone_conditioner gprd_checker u_gprd_checker (
  .clk (clk), .rst (rst), .start (start), .busy (busy), .done (done),
  .left_out_x (left_out_x), .left_out_y (left_out_y),
  .right_out_x (right_out_x), .right_out_y (right_out_y), .pready (pready)
);
`default_nettype wire
